[hdl/skt_pkg.sv]
package skt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int GRP_SIZE    = 16;
    localparam int GRP_W       = $clog2(GRP_SIZE);
    localparam int NUM_GRP     = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GSEL_W      = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int SLOT_W      = GSEL_W + GRP_W;
    localparam int PAD_DEPTH   = NUM_GRP * GRP_SIZE;

    typedef logic [1:0]       op_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [1:0]       status_t;
    typedef logic [7:0]       slot_t;
    typedef logic [8:0]       count_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_FIND   = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_DUPLICATE = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    typedef struct packed {
        logic    load;
        logic    cmp;
        logic    enc;
        logic    shift_ins;
        logic    shift_rem;
        logic    out_load;
        status_t status;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic hit;
        logic full;
    } stat_t;

endpackage

[hdl/skt_req_if.sv]
interface skt_req_if;
    import skt_pkg::*;

    logic valid;
    logic ready;
    op_t  operation;
    key_t agent_key;

    modport source (output valid, output operation, output agent_key, input ready);
    modport sink   (input valid, input operation, input agent_key, output ready);

endinterface

[hdl/skt_rsp_if.sv]
interface skt_rsp_if;
    import skt_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    slot_t   slot_index;
    count_t  entry_count;

    modport source (output valid, output status, output slot_index, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input entry_count,
                    output ready);

endinterface

[hdl/skt_ctrl.sv]
module skt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  skt_pkg::stat_t stat,
    output skt_pkg::cmd_t  cmd
);
    import skt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_ENC  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       req_fire;
    logic       out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_ENC;
            end
            S_ENC:
            begin
                cmd.enc    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.hit)
                            cmd.status = ST_DUPLICATE;
                        else if (stat.full)
                            cmd.status = ST_FULL;
                        else
                            cmd.shift_ins = out_free;
                    end
                    OP_REMOVE:
                    begin
                        if (stat.hit)
                            cmd.shift_rem = out_free;
                        else
                            cmd.status = ST_NOT_FOUND;
                    end
                    default:
                    begin
                        if (!stat.hit)
                            cmd.status = ST_NOT_FOUND;
                    end
                endcase
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fire_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == S_CMP)
        else $error("accepted request did not enter compare");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("result register overwritten while held");

    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift_ins && cmd.shift_rem))
        else $error("insert and remove shift together");

endmodule

[hdl/skt_datapath.sv]
module skt_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  skt_pkg::cmd_t    cmd,
    output skt_pkg::stat_t   stat,
    input  skt_pkg::op_t     operation,
    input  skt_pkg::key_t    agent_key,
    output skt_pkg::status_t status,
    output skt_pkg::slot_t   slot_index,
    output skt_pkg::count_t  entry_count
);
    import skt_pkg::*;

    key_t                   key_reg [TABLE_DEPTH];
    key_t                   key_up  [TABLE_DEPTH];
    key_t                   key_dn  [TABLE_DEPTH];
    key_t                   probe_reg;
    op_t                    op_reg;
    cnt_t                   count_reg;
    cnt_t                   count_next;
    logic [TABLE_DEPTH-1:0] lt_reg;
    logic [TABLE_DEPTH-1:0] eq_reg;
    logic [TABLE_DEPTH-1:0] bnd;
    logic [TABLE_DEPTH-1:0] bnd_reg;
    logic [PAD_DEPTH-1:0]   bnd_pad;
    logic [PAD_DEPTH-1:0]   eq_pad;
    logic [NUM_GRP-1:0]     grp_any_next;
    logic [NUM_GRP-1:0]     grp_any_reg;
    logic [NUM_GRP-1:0]     grp_hit_next;
    logic [NUM_GRP-1:0]     grp_hit_reg;
    logic [GRP_W-1:0]       grp_idx_next [NUM_GRP];
    logic [GRP_W-1:0]       grp_idx_reg  [NUM_GRP];
    logic [SLOT_W-1:0]      slot_sel;
    logic                   hit;
    logic                   full;
    status_t                status_reg;
    slot_t                  slot_reg;
    count_t                 count_out_reg;

    // lower-bound boundary: first cell whose key is not below the probe
    always_comb
    begin
        bnd[0] = !lt_reg[0];
        for (int i = 1; i < TABLE_DEPTH; i++)
            bnd[i] = !lt_reg[i] && lt_reg[i-1];
    end

    assign bnd_pad = PAD_DEPTH'(bnd);
    assign eq_pad  = PAD_DEPTH'(eq_reg);

    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_hit_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                if (bnd_pad[g*GRP_SIZE + k])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = grp_idx_next[g] | GRP_W'(k);
                    grp_hit_next[g] = grp_hit_next[g] | eq_pad[g*GRP_SIZE + k];
                end
            end
        end
    end

    always_comb
    begin
        slot_sel = '0;
        hit      = 1'b0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            if (grp_any_reg[g])
                slot_sel = slot_sel | {GSEL_W'(g), grp_idx_reg[g]};
            hit = hit | grp_hit_reg[g];
        end
    end

    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.op   = op_reg;
    assign stat.hit  = hit;
    assign stat.full = full;

    always_comb
    begin
        key_up[0]             = probe_reg;
        key_dn[TABLE_DEPTH-1] = key_reg[TABLE_DEPTH-1];
        for (int i = 1; i < TABLE_DEPTH; i++)
            key_up[i] = key_reg[i-1];
        for (int i = 0; i < TABLE_DEPTH - 1; i++)
            key_dn[i] = key_reg[i+1];
    end

    always_comb
    begin
        if (cmd.shift_ins)
            count_next = count_reg + 1'b1;
        else if (cmd.shift_rem)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            probe_reg <= agent_key;
            op_reg    <= operation;
        end
        if (cmd.cmp)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                lt_reg[i] <= (CNT_W'(i) < count_reg) && (key_reg[i] < probe_reg);
                eq_reg[i] <= (CNT_W'(i) < count_reg) && (key_reg[i] == probe_reg);
            end
        end
        if (cmd.enc)
        begin
            bnd_reg      <= bnd;
            grp_any_reg  <= grp_any_next;
            grp_hit_reg  <= grp_hit_next;
            grp_idx_reg  <= grp_idx_next;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cmd.shift_ins && !lt_reg[i])
                key_reg[i] <= bnd_reg[i] ? probe_reg : key_up[i];
            else if (cmd.shift_rem && !lt_reg[i])
                key_reg[i] <= key_dn[i];
        end
        if (cmd.out_load)
        begin
            status_reg    <= cmd.status;
            slot_reg      <= (cmd.status == ST_OK) ? slot_t'(slot_sel) : '0;
            count_out_reg <= count_t'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign entry_count = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("key count above table depth");

    a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_ins |-> !full && !hit)
        else $error("insert into full table or over existing key");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count not advanced after insert");

endmodule

[hdl/sorted_key_table.sv]
// sorted_key_table: ordered set of distinct 64-bit keys, one operation per request.
// req channel (sink): operation (insert, remove, find) and agent_key.
// rsp channel (source): status, slot_index, entry_count - one response per request.
// Each key sits in a cell of a row; a request is handled in these steps:
//   accept, parallel compare of every cell against the key, boundary encode
//   in groups of sixteen cells, then resolve, shift the row and load the
//   response register. rsp.valid rises when the response register is loaded;
//   a new request is accepted only after the previous one has passed the
//   accept, compare, encode and resolve states of the controller.
// Insert moves every cell at or past the lower-bound slot up by one; remove
// moves them down. Full table is reported when the count equals the depth;
// a duplicate is reported before fullness.
// Reset clears the key count and the response valid; cell contents are
// left as they are and are never read past the count.
// A held response does not block the next request: the request is processed
// and waits in its final stage until the response register is taken.
module sorted_key_table (
    input  logic      clk,
    input  logic      rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);
    import skt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    skt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (req.operation),
        .agent_key   (req.agent_key),
        .status      (rsp.status),
        .slot_index  (rsp.slot_index),
        .entry_count (rsp.entry_count)
    );

endmodule

[verif/tb_sorted_key_table.sv]
`timescale 1ns / 100ps

module tb_sorted_key_table;
    import skt_pkg::*;

    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      RANDOM_ITEMS = 850;
    localparam op_t     OP_SPARE     = 2'd3;
    localparam key_t    KEY_MAX      = '1;
    localparam key_t    KEY_MID      = 64'h8000_0000_0000_0000;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    typedef struct {
        op_t  op;
        key_t key;
    } table_request_t;

    typedef struct {
        status_t status;
        slot_t   slot;
        count_t  count;
    } table_response_t;

    logic clk;
    logic rst_n;

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    table_request_t  pending_requests[$];
    table_response_t expected_responses[$];
    key_t            held_keys[$];
    key_t            live_keys[$];
    table_request_t  next_req;
    table_response_t want_rsp;
    int              accepted_count = 0;
    int              request_total  = 0;
    int              error_count    = 0;
    int              cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ordered key set as the block should hold it
    function automatic void predict_table_op(op_t op, key_t key);
        int              pos;
        bit              hit;
        table_response_t rsp;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key)
            pos++;
        hit = (pos < held_keys.size()) && (held_keys[pos] == key);
        rsp.status = ST_OK;
        rsp.slot   = '0;
        case (op)
            OP_INSERT:
            begin
                if (hit)
                    rsp.status = ST_DUPLICATE;
                else if (held_keys.size() >= TABLE_DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    held_keys.insert(pos, key);
                    rsp.slot = slot_t'(pos);
                end
            end
            OP_REMOVE:
            begin
                if (!hit)
                    rsp.status = ST_NOT_FOUND;
                else
                begin
                    held_keys.delete(pos);
                    rsp.slot = slot_t'(pos);
                end
            end
            default:
            begin
                if (!hit)
                    rsp.status = ST_NOT_FOUND;
                else
                    rsp.slot = slot_t'(pos);
            end
        endcase
        rsp.count = count_t'(held_keys.size());
        expected_responses.push_back(rsp);
    endfunction

    function automatic int live_index(key_t key);
        for (int i = 0; i < live_keys.size(); i++)
            if (live_keys[i] == key)
                return i;
        return -1;
    endfunction

    // live_keys tracks what the table will hold, so stimulus can aim at hits
    function automatic void queue_request(op_t op, key_t key);
        int             idx;
        table_request_t item;
        idx = live_index(key);
        if (op == OP_INSERT && idx < 0 && live_keys.size() < TABLE_DEPTH)
            live_keys.push_back(key);
        else if (op == OP_REMOVE && idx >= 0)
            live_keys.delete(idx);
        item.op  = op;
        item.key = key;
        pending_requests.push_back(item);
        request_total++;
    endfunction

    function automatic key_t fresh_key();
        key_t base;
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return key_t'($urandom_range(31));
            2: return ~key_t'($urandom_range(31));
            default:
            begin
                if (live_keys.size() == 0)
                    return {$urandom, $urandom};
                base = live_keys[$urandom_range(live_keys.size() - 1)];
                return base ^ (key_t'(1) << $urandom_range(63));
            end
        endcase
    endfunction

    function automatic key_t pick_key(bit want_live);
        if (want_live && live_keys.size() != 0)
            return live_keys[$urandom_range(live_keys.size() - 1)];
        return fresh_key();
    endfunction

    function automatic void gen_one(int ins_pct, int rem_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            queue_request(OP_INSERT, pick_key($urandom_range(99) < 10));
        else if (roll < ins_pct + rem_pct)
            queue_request(OP_REMOVE, pick_key($urandom_range(99) < 80));
        else
            queue_request(($urandom_range(9) == 0) ? OP_SPARE : OP_FIND,
                          pick_key($urandom_range(99) < 70));
    endfunction

    function automatic int idle_phase();
        return (accepted_count / 100) % 4;
    endfunction

    function automatic bit sender_pause();
        case (idle_phase())
            IDLE_SENDER: return $urandom_range(99) < 57;
            IDLE_BOTH:   return $urandom_range(99) < 6;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_phase())
            IDLE_RECEIVER: return $urandom_range(99) < 57;
            IDLE_BOTH:     return $urandom_range(99) < 6;
            default:       return 1'b0;
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_INSERT;
            req_ch.agent_key <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_table_op(req_ch.operation, req_ch.agent_key);
                accepted_count <= accepted_count + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0 && !sender_pause())
                begin
                    next_req = pending_requests.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= next_req.op;
                    req_ch.agent_key <= next_req.key;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("unexpected response: status %0d slot_index %0d entry_count %0d",
                           rsp_ch.status, rsp_ch.slot_index, rsp_ch.entry_count);
                    error_count++;
                end
                else
                begin
                    want_rsp = expected_responses.pop_front();
                    if (rsp_ch.status !== want_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", want_rsp.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.slot_index !== want_rsp.slot)
                    begin
                        $error("slot_index: expected %0d, got %0d",
                               want_rsp.slot, rsp_ch.slot_index);
                        error_count++;
                    end
                    if (rsp_ch.entry_count !== want_rsp.count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want_rsp.count, rsp_ch.entry_count);
                        error_count++;
                    end
                end
            end
            rsp_ch.ready <= !receiver_stall();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sorted_key_table: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // empty table, extremes, duplicates, spare opcode, first and last slots
        queue_request(OP_FIND,   '0);
        queue_request(OP_REMOVE, key_t'(5));
        queue_request(OP_SPARE,  key_t'(7));
        queue_request(OP_INSERT, KEY_MID);
        queue_request(OP_INSERT, '0);
        queue_request(OP_INSERT, KEY_MAX);
        queue_request(OP_INSERT, key_t'(1));
        queue_request(OP_INSERT, KEY_MAX - 1);
        queue_request(OP_INSERT, KEY_MAX);
        queue_request(OP_INSERT, '0);
        queue_request(OP_FIND,   '0);
        queue_request(OP_FIND,   KEY_MAX);
        queue_request(OP_SPARE,  KEY_MAX);
        queue_request(OP_FIND,   key_t'(2));
        queue_request(OP_REMOVE, KEY_MID);
        queue_request(OP_REMOVE, KEY_MID);
        queue_request(OP_INSERT, 64'h5555_5555_5555_5555);
        queue_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(OP_FIND,   64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(OP_REMOVE, '0);
        queue_request(OP_REMOVE, KEY_MAX);
        queue_request(OP_INSERT, '0);

        // fill to capacity, hammer the full table, drain, then mixed traffic
        while (live_keys.size() < TABLE_DEPTH)
            gen_one(85, 5);
        repeat (15)
            gen_one(80, 5);
        while (live_keys.size() > 30)
            gen_one(10, 75);
        repeat (100)
            gen_one(40, 30);
        while (request_total < RANDOM_ITEMS)
            gen_one(40, 30);

        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("sorted_key_table: match");
        else
            $display("sorted_key_table: mismatch");
        $finish;
    end

endmodule
